/* rtl/event_debounce_throttle_merge_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef EVENT_DEBOUNCE_THROTTLE_MERGE_MACROS_SVH
`define EVENT_DEBOUNCE_THROTTLE_MERGE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define EDTM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("edtm check failed");

// Next-cycle implication, disabled while in reset.
`define EDTM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("edtm check failed");

`endif

/* rtl/edtm_pkg.sv */
package edtm_pkg;

  localparam int MERGE_DEPTH_DEF   = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;
  localparam int DELAY_W           = 16;
  localparam int MODE_W            = 2;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_IDX_W         = 1;
  localparam int JOBQ_DEPTH        = 2;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;

  // mode register codes (code 3 is unused)
  localparam logic [MODE_W-1:0] MODE_DEBOUNCE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_THROTTLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MERGE    = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'b1;

  // input action codes
  localparam logic ACT_EVENT = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic {
    JOB_SINGLE,
    JOB_MERGE
  } job_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_LOAD
  } back_state_e;

  typedef struct packed {
    logic run_done;
  } back_status_t;

endpackage

/* rtl/edtm_ram.sv */
module edtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/edtm_fifo.sv */
module edtm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/edtm_front.sv */
module edtm_front import edtm_pkg::*; #(
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
  parameter int MERGE_DEPTH   = MERGE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic [PAYLOAD_WIDTH-1:0]  payload_i,
  output logic                      ram_we_o,
  output logic [((MERGE_DEPTH > 1) ? $clog2(MERGE_DEPTH) : 1)-1:0] ram_waddr_o,
  output logic [PAYLOAD_WIDTH-1:0]  ram_wdata_o,
  output logic                      job_push_o,
  output logic [PAYLOAD_WIDTH+$clog2(MERGE_DEPTH+1)+1:0] job_data_o,
  input  logic                      job_full_i,
  input  back_status_t              back_status_i
);

  localparam int CNT_W  = $clog2(MERGE_DEPTH + 1);
  localparam int ADDR_W = (MERGE_DEPTH > 1) ? $clog2(MERGE_DEPTH) : 1;

  logic [MODE_W-1:0]        mode_q;
  logic [DELAY_W-1:0]       delay_q;
  logic                     running_q, running_d;
  logic [DELAY_W-1:0]       ticks_q, ticks_d;
  logic                     pending_q, pending_d;
  logic [PAYLOAD_WIDTH-1:0] held_q, held_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     drop_q, drop_d;
  logic                     run_busy_q, run_busy_d;

  logic                     accept;
  logic [DELAY_W-1:0]       start_val;
  job_kind_e                job_kind;
  logic [PAYLOAD_WIDTH-1:0] job_pay;
  logic                     job_ovf;

  // no new work while a merge run still reads the store
  assign in_stall_o  = job_full_i || run_busy_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign start_val   = (delay_q == '0) ? DELAY_W'(1) : delay_q;
  assign ram_waddr_o = count_q[ADDR_W-1:0];
  assign ram_wdata_o = payload_i;
  assign job_data_o  = {job_kind, job_pay, count_q, job_ovf};

  always_comb begin
    running_d  = running_q;
    ticks_d    = ticks_q;
    pending_d  = pending_q;
    held_d     = held_q;
    count_d    = count_q;
    drop_d     = drop_q;
    run_busy_d = run_busy_q && !back_status_i.run_done;
    job_push_o = 1'b0;
    job_kind   = JOB_SINGLE;
    job_pay    = held_q;
    job_ovf    = drop_q;
    ram_we_o   = 1'b0;

    if (accept) begin
      if (action_i == ACT_TICK) begin
        if (running_q) begin
          if (ticks_q > DELAY_W'(1)) begin
            ticks_d = ticks_q - DELAY_W'(1);
          end else begin
            ticks_d   = '0;
            running_d = 1'b0;
            unique case (mode_q)
              MODE_DEBOUNCE: begin
                if (pending_q) begin
                  job_push_o = 1'b1;
                  pending_d  = 1'b0;
                  held_d     = '0;
                end
              end
              MODE_THROTTLE: begin
                if (pending_q) begin
                  job_push_o = 1'b1;
                  pending_d  = 1'b0;
                  held_d     = '0;
                  running_d  = 1'b1;
                  ticks_d    = start_val;
                end
              end
              MODE_MERGE: begin
                if (count_q != '0) begin
                  job_push_o = 1'b1;
                  job_kind   = JOB_MERGE;
                  count_d    = '0;
                  drop_d     = 1'b0;
                  pending_d  = 1'b0;
                  run_busy_d = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end else begin
        unique case (mode_q)
          MODE_DEBOUNCE: begin
            held_d    = payload_i;
            pending_d = 1'b1;
            running_d = 1'b1;
            ticks_d   = start_val;
          end
          MODE_THROTTLE: begin
            if (!running_q) begin
              job_push_o = 1'b1;
              job_pay    = payload_i;
              pending_d  = 1'b0;
              held_d     = '0;
              running_d  = 1'b1;
              ticks_d    = start_val;
            end else begin
              held_d    = payload_i;
              pending_d = 1'b1;
            end
          end
          MODE_MERGE: begin
            if (count_q < CNT_W'(MERGE_DEPTH)) begin
              ram_we_o = 1'b1;
              count_d  = count_q + CNT_W'(1);
            end else begin
              drop_d = 1'b1;
            end
            pending_d = 1'b1;
            if (!running_q) begin
              running_d = 1'b1;
              ticks_d   = start_val;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_DEBOUNCE;
      delay_q    <= DELAY_RESET;
      running_q  <= 1'b0;
      ticks_q    <= '0;
      pending_q  <= 1'b0;
      held_q     <= '0;
      count_q    <= '0;
      drop_q     <= 1'b0;
      run_busy_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MODE:  mode_q  <= cfg_wdata_i[MODE_W-1:0];
          REG_DELAY: delay_q <= cfg_wdata_i[DELAY_W-1:0];
          default: ;
        endcase
      end
      running_q  <= running_d;
      ticks_q    <= ticks_d;
      pending_q  <= pending_d;
      held_q     <= held_d;
      count_q    <= count_d;
      drop_q     <= drop_d;
      run_busy_q <= run_busy_d;
    end
  end

endmodule

/* rtl/edtm_back.sv */
module edtm_back import edtm_pkg::*; #(
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
  parameter int MERGE_DEPTH   = MERGE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [PAYLOAD_WIDTH+$clog2(MERGE_DEPTH+1)+1:0] job_data_i,
  input  logic                      job_empty_i,
  output logic                      job_pop_o,
  output logic                      ram_re_o,
  output logic [((MERGE_DEPTH > 1) ? $clog2(MERGE_DEPTH) : 1)-1:0] ram_raddr_o,
  input  logic [PAYLOAD_WIDTH-1:0]  ram_rdata_i,
  output back_status_t              status_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [PAYLOAD_WIDTH-1:0]  out_payload_o,
  output logic                      last_of_run_o,
  output logic                      overflowed_o
);

  localparam int CNT_W  = $clog2(MERGE_DEPTH + 1);
  localparam int ADDR_W = (MERGE_DEPTH > 1) ? $clog2(MERGE_DEPTH) : 1;
  localparam int JOB_W  = PAYLOAD_WIDTH + CNT_W + 2;

  back_state_e              state_q, state_d;
  logic [CNT_W-1:0]         idx_q, idx_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     ovf_q, ovf_d;
  logic                     out_valid_q;
  logic [PAYLOAD_WIDTH-1:0] out_pay_q;
  logic                     out_last_q, out_ovf_q;

  job_kind_e                job_kind;
  logic [PAYLOAD_WIDTH-1:0] job_pay;
  logic [CNT_W-1:0]         job_cnt;
  logic                     job_ovf;
  logic                     out_free;
  logic                     load;
  logic [PAYLOAD_WIDTH-1:0] load_pay;
  logic                     load_last, load_ovf;
  logic                     run_last;

  assign job_kind = job_kind_e'(job_data_i[JOB_W-1]);
  assign job_pay  = job_data_i[JOB_W-2 -: PAYLOAD_WIDTH];
  assign job_cnt  = job_data_i[CNT_W:1];
  assign job_ovf  = job_data_i[0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign run_last = ((idx_q + CNT_W'(1)) == cnt_q);
  assign ram_raddr_o = idx_q[ADDR_W-1:0];

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    job_pop_o = 1'b0;
    ram_re_o  = 1'b0;
    load      = 1'b0;
    load_pay  = job_pay;
    load_last = 1'b1;
    load_ovf  = 1'b0;
    status_o  = '0;

    unique case (state_q)
      BK_IDLE: begin
        if (!job_empty_i && out_free) begin
          job_pop_o = 1'b1;
          if (job_kind == JOB_SINGLE) begin
            load = 1'b1;
          end else begin
            cnt_d   = job_cnt;
            ovf_d   = job_ovf;
            idx_d   = '0;
            state_d = BK_FETCH;
          end
        end
      end
      BK_FETCH: begin
        ram_re_o = 1'b1;
        state_d  = BK_LOAD;
      end
      BK_LOAD: begin
        if (out_free) begin
          load      = 1'b1;
          load_pay  = ram_rdata_i;
          load_last = run_last;
          load_ovf  = ovf_q;
          idx_d     = idx_q + CNT_W'(1);
          if (run_last) begin
            status_o.run_done = 1'b1;
            state_d           = BK_IDLE;
          end else begin
            state_d = BK_FETCH;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    ovf_q <= ovf_d;
    if (load) begin
      out_pay_q  <= load_pay;
      out_last_q <= load_last;
      out_ovf_q  <= load_ovf;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_pay_q;
  assign last_of_run_o = out_last_q;
  assign overflowed_o  = out_ovf_q;

endmodule

/* rtl/event_debounce_throttle_merge.sv */
// Flow: a taken tick or event pushes any delivery it causes into the job queue; the back
//   end pops it and loads a single payload into the output register, while a merge run
//   goes item by item through a store read (FETCH) and an output load (LOAD).
// Throughput: 1 input transaction per cycle, stalled while a merge run drains or the
//   2-entry job queue is full. The job queue absorbs output stalls until it fills.
// Reset: async active low; timer, flags, counts, queue and output valid clear at once.
module event_debounce_throttle_merge import edtm_pkg::*; #(
  parameter int MERGE_DEPTH   = MERGE_DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [PAYLOAD_WIDTH-1:0] payload_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [PAYLOAD_WIDTH-1:0] out_payload_o,
  output logic                     last_of_run_o,
  output logic                     overflowed_o
);

  localparam int CNT_W  = $clog2(MERGE_DEPTH + 1);
  localparam int ADDR_W = (MERGE_DEPTH > 1) ? $clog2(MERGE_DEPTH) : 1;
  // job word: kind, single payload, merge count, overflow flag
  localparam int JOB_W  = PAYLOAD_WIDTH + CNT_W + 2;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [PAYLOAD_WIDTH-1:0] ram_wdata;
  logic                     ram_re;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [PAYLOAD_WIDTH-1:0] ram_rdata;

  logic                     job_push, job_full, job_pop, job_empty;
  logic [JOB_W-1:0]         job_wdata, job_rdata;
  back_status_t             back_status;

  // Front end: config registers, countdown timer, pending/held payload and merge
  // bookkeeping. Every transaction is classified and retired in the cycle it is accepted; any
  // delivery it causes leaves as a job (single payload, or a merge run of N entries).
  edtm_front #(
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .MERGE_DEPTH   (MERGE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .payload_i     (payload_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .job_push_o    (job_push),
    .job_data_o    (job_wdata),
    .job_full_i    (job_full),
    .back_status_i (back_status)
  );

  // Merge store: written by the front at the fill index, read by the back during a
  // flush. The front holds off input until the back reports the run done, so a new
  // merge window never overwrites entries still waiting to go out.
  edtm_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (MERGE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Job queue between front and back.
  edtm_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_wdata),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_rdata),
    .empty_o (job_empty)
  );

  // Back end: turns jobs into output transactions. Single jobs load the output
  // register directly; merge jobs step through the store, one read per item.
  edtm_back #(
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .MERGE_DEPTH   (MERGE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_data_i    (job_rdata),
    .job_empty_i   (job_empty),
    .job_pop_o     (job_pop),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .status_o      (back_status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_payload_o (out_payload_o),
    .last_of_run_o (last_of_run_o),
    .overflowed_o  (overflowed_o)
  );

endmodule

/* rtl/edtm_checker.sv */
`include "event_debounce_throttle_merge_macros.svh"

module edtm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic last_of_run_o,
  input logic overflowed_o
);

  // a stalled output transaction stays offered
  `EDTM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // mid-run items only appear while input is held off for the merge flush
  `EDTM_ASSERT_IMP(a_run_blocks_in, clk_i, rst_ni, out_valid_o && !last_of_run_o, in_stall_o)

  // overflow flag is the same on back-to-back items of one run
  `EDTM_ASSERT_NXT(a_run_ovf_const, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_of_run_o, !out_valid_o || (overflowed_o == $past(overflowed_o)))

endmodule

bind event_debounce_throttle_merge edtm_checker u_edtm_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import edtm_pkg::*;

  localparam int PW          = PAYLOAD_WIDTH_DEF;
  localparam int DEPTH       = MERGE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYC  = 10;   // margin once the last predicted delivery is seen
  localparam int SHOWN_MAX   = 10;

  // Mode code 3 has no name in the package: events are ignored there.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // One delivery to the handler, as seen on the output channel.
  typedef struct packed {
    logic [PW-1:0] word;
    logic          last;
    logic          ovf;
  } delivery_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic [PW-1:0]         payload_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [PW-1:0]         out_payload_o;
  logic                  last_of_run_o;
  logic                  overflowed_o;

  event_debounce_throttle_merge dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_payload_o (out_payload_o),
    .last_of_run_o (last_of_run_o),
    .overflowed_o  (overflowed_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Idling percentages, changed by the random traffic test between traffic phases.
  int idle_pct  = 26;
  int stall_pct = 54;

  int mismatches  = 0;
  int items_sent  = 0;
  int cycle_count = 0;

  // Deliveries predicted but not yet seen on the output, oldest first.
  delivery_t expected_deliveries[$];

  // ---------------------------------------------------------------------------
  // Limiter prediction: private copy of registers and state, reset values.
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]  lim_mode     = MODE_DEBOUNCE;
  logic [DELAY_W-1:0] lim_delay    = DELAY_RESET;
  logic               tmr_on       = 1'b0;
  logic [DELAY_W-1:0] tmr_left     = '0;
  logic               held_pending = 1'b0;
  logic [PW-1:0]      held_word    = '0;
  logic [PW-1:0]      merge_buf [DEPTH];
  int                 merge_n      = 0;
  logic               merge_drop   = 1'b0;

  // One-shot timer start; a zero length behaves as one tick.
  task automatic arm_timer();
    tmr_left = (lim_delay == '0) ? DELAY_W'(1) : lim_delay;
    tmr_on   = 1'b1;
  endtask

  // Advance the prediction by one accepted transaction and queue whatever
  // deliveries it triggers.
  task automatic predict_limiter(input logic act, input logic [PW-1:0] word);
    int i;
    if (act == ACT_TICK) begin
      // ticks only matter while the timer runs; payload is don't-care
      if (!tmr_on) return;
      if (tmr_left != '0) tmr_left--;
      if (tmr_left != '0) return;
      tmr_on = 1'b0;
      // expiry acts per the mode in force right now
      case (lim_mode)
        MODE_DEBOUNCE: begin
          if (held_pending) begin
            expected_deliveries.push_back('{held_word, 1'b1, 1'b0});
            held_pending = 1'b0;
            held_word    = '0;
          end
        end
        MODE_THROTTLE: begin
          // held event goes out and the window reopens
          if (held_pending) begin
            expected_deliveries.push_back('{held_word, 1'b1, 1'b0});
            held_pending = 1'b0;
            held_word    = '0;
            arm_timer();
          end
        end
        MODE_MERGE: begin
          if (merge_n > 0) begin
            for (i = 0; i < merge_n; i++)
              expected_deliveries.push_back('{merge_buf[i], i == merge_n - 1, merge_drop});
            merge_n      = 0;
            merge_drop   = 1'b0;
            held_pending = 1'b0;
          end
        end
        default: ;  // unused mode: expiry delivers nothing
      endcase
      return;
    end

    case (lim_mode)
      MODE_DEBOUNCE: begin
        // every event restarts the timer and replaces the held word
        held_word    = word;
        held_pending = 1'b1;
        arm_timer();
      end
      MODE_THROTTLE: begin
        if (!tmr_on) begin
          // first event passes straight through and opens the window
          expected_deliveries.push_back('{word, 1'b1, 1'b0});
          held_pending = 1'b0;
          held_word    = '0;
          arm_timer();
        end else begin
          held_word    = word;
          held_pending = 1'b1;
        end
      end
      MODE_MERGE: begin
        // full buffer drops the event and flags the run
        if (merge_n < DEPTH) begin
          merge_buf[merge_n] = word;
          merge_n++;
        end else begin
          merge_drop = 1'b1;
        end
        held_pending = 1'b1;
        if (!tmr_on) arm_timer();
      end
      default: ;  // unused mode: events ignored
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, and an in-order check of every transaction.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin : check_deliveries
    delivery_t got;
    delivery_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_payload_o, last_of_run_o, overflowed_o};
      if (expected_deliveries.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("unexpected delivery: payload %h last %b ovf %b",
                   got.word, got.last, got.ovf);
      end else begin
        want = expected_deliveries.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("delivery mismatch: expected payload %h last %b ovf %b, got %h %b %b",
                     want.word, want.last, want.ovf, got.word, got.last, got.ovf);
        end
      end
    end
  end

  // Watchdog: a hung handshake or lost delivery ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. All tasks start and end at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one transaction, with random idle cycles ahead of it, and hold it
  // until the block takes it.
  task automatic send_item(input logic act, input logic [PW-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    payload_i  <= word;
    do @(posedge clk_i); while (in_stall_o);
    predict_limiter(act, word);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drain: nothing offered, every predicted delivery seen, then a few more
  // cycles for ticks and events still inside the block.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_deliveries.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write both registers back to back while the block is quiet.
  task automatic configure(input logic [MODE_W-1:0] m, input logic [DELAY_W-1:0] d);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MODE;
    cfg_wdata_i <= CFG_DATA_W'(m);
    @(posedge clk_i);
    lim_mode = m;
    @(negedge clk_i);
    cfg_idx_i   <= REG_DELAY;
    cfg_wdata_i <= CFG_DATA_W'(d);
    @(posedge clk_i);
    lim_delay = d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Restart on every event; only the last word comes out, at expiry.
  task automatic test_debounce();
    configure(MODE_DEBOUNCE, 16'd2);
    send_item(ACT_EVENT, '0);
    send_item(ACT_TICK, '1);
    send_item(ACT_EVENT, '1);   // restarts the countdown
    send_item(ACT_TICK, '0);
    send_item(ACT_TICK, $urandom());
  endtask

  // Pass-through, hold inside the window, reopen on expiry, then close when
  // nothing was held.
  task automatic test_throttle();
    configure(MODE_THROTTLE, 16'd1);
    send_item(ACT_EVENT, $urandom());
    send_item(ACT_EVENT, $urandom());
    send_item(ACT_TICK, $urandom());
    send_item(ACT_TICK, $urandom());
  endtask

  // Longest timer, unused mode, and a mode change while the timer runs; the
  // merge entry left behind is picked up by the overflow test.
  task automatic test_mode_switch();
    configure(MODE_MERGE, 16'hFFFF);
    send_item(ACT_EVENT, $urandom());
    send_item(ACT_TICK, $urandom());
    configure(MODE_UNUSED, 16'd1);
    send_item(ACT_EVENT, $urandom());   // ignored
    send_item(ACT_TICK, $urandom());    // still counts down
    configure(MODE_DEBOUNCE, 16'd1);
    send_item(ACT_EVENT, $urandom());   // restarts with the short length
    send_item(ACT_TICK, $urandom());
    send_item(ACT_TICK, $urandom());    // timer stopped: no effect
  endtask

  // Zero length timer; buffer fills up past its depth and the run carries
  // the overflow flag on every item.
  task automatic test_merge_overflow();
    int k;
    configure(MODE_MERGE, 16'd0);
    for (k = 0; k < DEPTH; k++)
      send_item(ACT_EVENT, (k == 0) ? '0 : (k == 1) ? '1 : PW'($urandom()));
    send_item(ACT_TICK, $urandom());
  endtask

  // Random settings per segment; traffic is mostly event bursts followed by
  // enough ticks to expire, with stray ticks and short windows mixed in.
  task automatic test_random_traffic(input int idle, input int stall, input int n_items);
    int stop_at;
    int seg_end;
    int n_ev;
    int n_tk;
    int r;
    logic [MODE_W-1:0]  m;
    logic [DELAY_W-1:0] d;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(9);
      m = (r < 3) ? MODE_DEBOUNCE : (r < 6) ? MODE_THROTTLE :
          (r < 9) ? MODE_MERGE : MODE_UNUSED;
      r = $urandom_range(9);
      d = (r == 0) ? '0 : (r == 1) ? DELAY_W'($urandom_range(8, 20)) :
          DELAY_W'($urandom_range(1, 4));
      configure(m, d);
      seg_end = items_sent + $urandom_range(20, 35);
      while (items_sent < seg_end) begin
        if ($urandom_range(7) == 0) begin
          send_item(1'($urandom_range(1)), $urandom());
        end else begin
          // long merge bursts run into the buffer limit
          n_ev = (m == MODE_MERGE && $urandom_range(3) == 0) ?
                 $urandom_range(14, 20) : $urandom_range(1, 4);
          repeat (n_ev) begin
            send_item(ACT_EVENT, $urandom());
            if ($urandom_range(4) == 0) send_item(ACT_TICK, $urandom());
          end
          n_tk = ((d == '0) ? 1 : int'(d)) + $urandom_range(0, 2);
          if ($urandom_range(5) == 0) n_tk = $urandom_range(0, n_tk);  // cut short
          repeat (n_tk) send_item(ACT_TICK, $urandom());
        end
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_MODE;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    action_i    = ACT_EVENT;
    payload_i   = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_debounce();
    test_throttle();
    test_mode_switch();
    test_merge_overflow();
    test_random_traffic(26, 54, 80);
    test_random_traffic(54, 26, 80);
    test_random_traffic(0, 0, 80);

    settle();
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/edtm_pkg.sv
rtl/edtm_ram.sv
rtl/edtm_fifo.sv
rtl/edtm_front.sv
rtl/edtm_back.sv
rtl/event_debounce_throttle_merge.sv
rtl/edtm_checker.sv
test/testbench.sv
